FILE: design/digit_key_shift_cipher_unit_assert.svh
// Assertion macros used by the cipher RTL.
`ifndef DIGIT_KEY_SHIFT_CIPHER_UNIT_ASSERT_SVH
`define DIGIT_KEY_SHIFT_CIPHER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DKC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dkc: implication check failed");

// Next-cycle implication, checked out of reset.
`define DKC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dkc: next-cycle check failed");

`endif

FILE: design/dkc_pkg.sv
package dkc_pkg;

  localparam int unsigned PointW = 21;
  localparam int unsigned DigitW = 4;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned LenW   = 5;
  localparam int unsigned PosW   = 4;
  localparam int unsigned SlotW  = 7;

  // Configuration register indexes
  localparam logic [1:0] RegKeyDigits = 2'd0;
  localparam logic [1:0] RegKeyLength = 2'd1;
  localparam logic [1:0] RegDirection = 2'd2;

  localparam logic [PointW-1:0] AsciiLow   = 21'd32;
  localparam logic [PointW-1:0] AsciiHigh  = 21'd126;
  localparam logic [SlotW-1:0]  AsciiSpan  = 7'(126 - 32 + 1);
  localparam logic [SlotW-1:0]  CyrSpan    = 7'd33;
  localparam logic [SlotW-1:0]  CyrExtra   = 7'd32;
  localparam logic [PointW-1:0] CyrUpBase  = 21'h000410;
  localparam logic [PointW-1:0] CyrUpExtra = 21'h000401;
  localparam logic [PointW-1:0] CyrLoBase  = 21'h000430;
  localparam logic [PointW-1:0] CyrLoExtra = 21'h000451;

  typedef struct packed {
    logic [PointW-1:0] code_point;
    logic              message_start;
  } in_item_t;

  typedef struct packed {
    logic [PointW-1:0] result_point;
  } out_item_t;

  typedef struct packed {
    logic [1:0]      index;
    logic [KeyW-1:0] value;
  } cfg_item_t;

  // Shift selected for one item, handed from key scheduler to datapath
  typedef struct packed {
    logic [DigitW-1:0] shift;
    logic              decrypt;
  } key_sel_t;

endpackage

FILE: design/dkc_chan_if.sv
interface dkc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/dkc_key_sched.sv
module dkc_key_sched #(
  parameter int unsigned MAX_KEY_DIGITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dkc_chan_if.sink          cfg_i,
  input  logic              accept_i,
  input  logic              message_start_i,
  output dkc_pkg::key_sel_t key_o
);
  import dkc_pkg::*;

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_KEY_DIGITS);

  logic [KeyW-1:0] key_digits_q;
  logic [LenW-1:0] key_length_q;
  logic            direction_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [LenW-1:0] len;
  logic [PosW-1:0] pos_eff;
  logic [LenW-1:0] pos_inc;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (key_length_q == '0) begin
      len = LenW'(1);
    end else if (key_length_q > MaxLen) begin
      len = MaxLen;
    end else begin
      len = key_length_q;
    end
    // a stale position past a shortened key falls back to digit zero
    pos_eff = (message_start_i || ({1'b0, pos_q} >= len)) ? '0 : pos_q;
    pos_inc = {1'b0, pos_eff} + LenW'(1);
    pos_d   = (pos_inc >= len) ? '0 : pos_inc[PosW-1:0];
    key_o.shift   = key_digits_q[{pos_eff, 2'b00} +: DigitW];
    key_o.decrypt = direction_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_digits_q <= '0;
      key_length_q <= LenW'(1);
      direction_q  <= 1'b0;
      pos_q        <= '0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.data.index)
          RegKeyDigits: key_digits_q <= cfg_i.data.value;
          RegKeyLength: key_length_q <= cfg_i.data.value[LenW-1:0];
          RegDirection: direction_q  <= cfg_i.data.value[0];
          default: ;
        endcase
      end
      if (accept_i) begin
        pos_q <= pos_d;
      end
    end
  end

endmodule

FILE: design/dkc_rotate.sv
module dkc_rotate (
  input  logic [dkc_pkg::PointW-1:0] code_point_i,
  input  dkc_pkg::key_sel_t          key_i,
  output logic [dkc_pkg::PointW-1:0] result_point_o
);
  import dkc_pkg::*;

  logic              ascii_hit, up_hit, lo_hit;
  logic [PointW-1:0] base, extra;
  logic [SlotW-1:0]  slot, span;
  logic [SlotW:0]    sum, wrapped;

  always_comb begin
    ascii_hit = (code_point_i >= AsciiLow) && (code_point_i <= AsciiHigh);
    up_hit    = ((code_point_i >= CyrUpBase) && (code_point_i <= CyrUpBase + PointW'(31)))
                || (code_point_i == CyrUpExtra);
    lo_hit    = ((code_point_i >= CyrLoBase) && (code_point_i <= CyrLoBase + PointW'(31)))
                || (code_point_i == CyrLoExtra);

    base  = up_hit ? CyrUpBase : CyrLoBase;
    extra = up_hit ? CyrUpExtra : CyrLoExtra;
    span  = ascii_hit ? AsciiSpan : CyrSpan;

    if (ascii_hit) begin
      slot = SlotW'(code_point_i - AsciiLow);
    end else if (code_point_i == extra) begin
      slot = CyrExtra;
    end else begin
      slot = SlotW'(code_point_i - base);
    end

    // both cases land below twice the span, so one conditional subtract wraps
    if (key_i.decrypt) begin
      sum = {1'b0, slot} + {1'b0, span} - (SlotW+1)'(key_i.shift);
    end else begin
      sum = {1'b0, slot} + (SlotW+1)'(key_i.shift);
    end
    wrapped = (sum >= {1'b0, span}) ? sum - {1'b0, span} : sum;

    if (ascii_hit) begin
      result_point_o = AsciiLow + PointW'(wrapped);
    end else if (up_hit || lo_hit) begin
      result_point_o = (wrapped[SlotW-1:0] == CyrExtra) ? extra : base + PointW'(wrapped);
    end else begin
      result_point_o = code_point_i;
    end
  end

endmodule

FILE: design/digit_key_shift_cipher_unit.sv
// channel | dir | payload                         | handshake
// cfg_i   | in  | index[1:0], value[63:0]         | valid/ready, always ready
// in_i    | in  | code_point[20:0], message_start | valid/ready
// out_o   | out | result_point[20:0]              | valid/ready
//
// One item per cycle sustained while out_o is ready; an item passes from in_i through the stage
// register and the output register before out_o can accept it. The key position counter updates at
// accept, so the next item sees it at once. Stage register plus output register: while a result
// waits, in_i takes one more item, then drops ready until out_o moves.
// Async active-low reset clears config to key 0, length 1, encrypt, position 0.
module digit_key_shift_cipher_unit #(
  parameter int unsigned MAX_KEY_DIGITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dkc_chan_if.sink   cfg_i,
  dkc_chan_if.sink   in_i,
  dkc_chan_if.source out_o
);
  import dkc_pkg::*;

  `include "digit_key_shift_cipher_unit_assert.svh"

  key_sel_t          key_sel;
  logic              in_acc;
  logic              s1_valid_q;
  logic [PointW-1:0] s1_point_q;
  key_sel_t          s1_key_q;
  logic              s1_adv;
  logic              out_free;
  logic [PointW-1:0] rot_point;
  logic              out_valid_q;
  logic [PointW-1:0] out_point_q;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  dkc_key_sched #(
    .MAX_KEY_DIGITS(MAX_KEY_DIGITS)
  ) u_key_sched (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_i),
    .accept_i       (in_acc),
    .message_start_i(in_i.data.message_start),
    .key_o          (key_sel)
  );

  dkc_rotate u_rotate (
    .code_point_i  (s1_point_q),
    .key_i         (s1_key_q),
    .result_point_o(rot_point)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_point_q <= in_i.data.code_point;
      s1_key_q   <= key_sel;
    end
    if (s1_adv) begin
      out_point_q <= rot_point;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.data.result_point = out_point_q;

  `DKC_ASSERT_NEXT(a_zero_shift_identity, s1_adv && (s1_key_q.shift == '0),
                   out_point_q == $past(s1_point_q))
  `DKC_ASSERT_NEXT(a_stage_holds, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_point_q))
  `DKC_ASSERT_NEXT(a_advance_fills_out, s1_adv, out_valid_q)

endmodule
